/* sv/streaming_phrase_matcher_assert.svh */
// ----------------------------------------------------------------------------
// Streaming phrase matcher assertion macros
// Shared concurrent assertion forms used by the matcher's checks.
// ----------------------------------------------------------------------------
`ifndef STREAMING_PHRASE_MATCHER_ASSERT_SVH
`define STREAMING_PHRASE_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/spm_pkg.sv */
// ----------------------------------------------------------------------------
// Streaming phrase matcher package
// Request and response types, register indexes and codes for the matcher.
// ----------------------------------------------------------------------------
package spm_pkg;

   localparam int MAX_PATTERN_DEFAULT = 8;
   localparam int COLUMN_BITS_DEFAULT = 16;

   localparam int PATTERN_BITS = 64;
   localparam int LENGTH_BITS  = 4;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_BYTES  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 1'd1;

   localparam logic REQ_TEXT = 1'b0;
   localparam logic REQ_END  = 1'b1;

   localparam logic KIND_MATCH = 1'b0;
   localparam logic KIND_TOTAL = 1'b1;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   typedef struct packed {
      logic       req_type;
      logic [7:0] text_byte;
   } spm_req_type;

   typedef struct packed {
      logic        result_kind;
      logic [31:0] match_line;
      logic [15:0] match_column;
      logic [31:0] found_total;
   } spm_rsp_type;

endpackage

/* sv/streaming_phrase_matcher.sv */
// ----------------------------------------------------------------------------
// Streaming phrase matcher
// Byte-stream substring search reporting line, column and running total.
// ----------------------------------------------------------------------------
// The matcher accepts one request per clock cycle while not stalled, text
// bytes or an end marker, and produces at most one response per request,
// registered, visible in the cycle after acceptance. All work for a byte (the
// window shift, the compare against every possible pattern length, and the
// line, column and count updates) is done in a single pass of logic between
// the request port and the response register, so the sustained rate is one
// request per cycle. The response register holds a result until it is taken;
// the input stalls only while that register is full and the downstream side
// stalls. A match is reported when the newest pattern_length bytes equal the
// pattern and all lie in the current line (the final byte may be the
// newline). Overlapping matches all count. An end request returns the running
// total with zero line and column and leaves all state untouched. Line and
// match counters saturate at 2^32-1, the column at 2^COLUMN_BITS-1. The
// configuration registers may only be written while the matcher is idle.
// ----------------------------------------------------------------------------
module streaming_phrase_matcher
   import spm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
   parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  spm_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output spm_rsp_type               rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [PATTERN_BITS-1:0]   csr_wdata
);

   `include "streaming_phrase_matcher_assert.svh"

   // Configuration registers.
   logic [PATTERN_BITS-1:0] pattern_ff;
   logic [LENGTH_BITS-1:0]  length_ff;

   // Matcher state.
   logic [7:0]             window_ff [MAX_PATTERN];
   logic [7:0]             window_in [MAX_PATTERN];
   logic [31:0]            line_ff, line_in;
   logic [COLUMN_BITS-1:0] column_ff, column_in;
   logic [31:0]            count_ff, count_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   spm_rsp_type rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic                   is_text;
   logic                   is_newline;
   logic [LENGTH_BITS-1:0] eff_length;
   logic [LENGTH_BITS-1:0] eff_length_m1;
   logic [MAX_PATTERN-1:0] hit_by_length;
   logic                   hit;
   logic [COLUMN_BITS-1:0] start_column;
   logic [COLUMN_BITS+15:0] start_column_ext;

   // A new request may enter whenever the response register is free or is
   // being drained in this same cycle.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign is_text    = (req_data.req_type == REQ_TEXT);
   assign is_newline = (req_data.text_byte == NEWLINE_BYTE);

   // Length zero acts as one; lengths beyond the window act as its depth.
   always_comb begin
      if (length_ff == '0) begin
         eff_length = LENGTH_BITS'(1);
      end else if (length_ff > LENGTH_BITS'(MAX_PATTERN)) begin
         eff_length = LENGTH_BITS'(MAX_PATTERN);
      end else begin
         eff_length = length_ff;
      end
   end
   assign eff_length_m1 = eff_length - LENGTH_BITS'(1);

   // Shifted window: entry 0 holds the incoming byte.
   always_comb begin
      window_in[0] = req_data.text_byte;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   // Compare against every candidate length at once, then pick the one in use.
   always_comb begin
      for (int l = 0; l < MAX_PATTERN; l++) begin
         hit_by_length[l] = 1'b1;
         for (int k = 0; k <= l; k++) begin
            if (window_in[l-k] != pattern_ff[8*k +: 8]) begin
               hit_by_length[l] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      hit = 1'b0;
      for (int l = 0; l < MAX_PATTERN; l++) begin
         if (eff_length_m1 == LENGTH_BITS'(l)) begin
            hit = hit_by_length[l];
         end
      end
      // Every matched byte must belong to the current line.
      if (column_ff < COLUMN_BITS'(eff_length_m1)) begin
         hit = 1'b0;
      end
   end

   assign start_column     = column_ff - COLUMN_BITS'(eff_length_m1);
   assign start_column_ext = {16'd0, start_column};

   // Counter updates for a text byte.
   always_comb begin
      count_in  = count_ff;
      line_in   = line_ff;
      column_in = column_ff;
      if (hit && (count_ff != '1)) begin
         count_in = count_ff + 32'd1;
      end
      if (is_newline) begin
         if (line_ff != '1) begin
            line_in = line_ff + 32'd1;
         end
         column_in = '0;
      end else if (column_ff != '1) begin
         column_in = column_ff + COLUMN_BITS'(1);
      end
   end

   // Response for the request being accepted.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         if (!is_text) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.result_kind  = KIND_TOTAL;
            rsp_data_in.match_line   = '0;
            rsp_data_in.match_column = '0;
            rsp_data_in.found_total  = count_ff;
         end else begin
            rsp_valid_in             = hit;
            rsp_data_in.result_kind  = KIND_MATCH;
            // A match closed by a newline started on the line just ended.
            rsp_data_in.match_line   = is_newline ? (line_in - 32'd1) : line_ff;
            rsp_data_in.match_column = start_column_ext[15:0];
            rsp_data_in.found_total  = count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         length_ff    <= LENGTH_BITS'(1);
         line_ff      <= '0;
         column_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_PATTERN; j++) begin
            window_ff[j] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_BYTES:  pattern_ff <= csr_wdata;
               CSR_PATTERN_LENGTH: length_ff  <= csr_wdata[LENGTH_BITS-1:0];
               default: ;
            endcase
         end
         if (req_accept && is_text) begin
            line_ff   <= line_in;
            column_ff <= column_in;
            count_ff  <= count_in;
            for (int j = 0; j < MAX_PATTERN; j++) begin
               window_ff[j] <= window_in[j];
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A held response must never be overwritten by a new request.
   `SPM_ASSERT_NOW(a_no_accept_when_blocked, clock, reset, rsp_valid_ff && rsp_stall, !req_accept, "request accepted while response blocked")
   // The match count never goes backward.
   `SPM_ASSERT_NEXT(a_count_monotonic, clock, reset, 1'b1, count_ff >= $past(count_ff), "match count decreased")
   // A newline always restarts the column.
   `SPM_ASSERT_NEXT(a_newline_clears_column, clock, reset, req_accept && is_text && is_newline, column_ff == '0, "column not cleared by newline")
   // A reported match is always included in the total it carries.
   `SPM_ASSERT_NOW(a_match_total_nonzero, clock, reset, rsp_valid_ff && (rsp_data_ff.result_kind == KIND_MATCH), rsp_data_ff.found_total != '0, "match reported with zero total")

endmodule
